// ===== hdl/rws_pkg.sv =====
// Shared types, constants and tables of the Ricker wavelet sample unit.
// Depends on nothing; every other file takes its names from here.
package rws_pkg;

    localparam int INDEX_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int NS_WIDTH         = 17;
    localparam int CMP_WIDTH        = ((INDEX_WIDTH > NS_WIDTH) ? INDEX_WIDTH : NS_WIDTH) + 1;
    localparam int POS_WIDTH        = INDEX_WIDTH + 32;
    localparam int A_WIDTH          = 37;
    localparam int N_WIDTH          = 6;
    localparam int N_MAX            = 34;
    localparam int K_WIDTH          = 4;
    localparam int HORNER_TERMS     = 12;
    localparam int AMP_WIDTH        = 24;

    localparam logic [30:0] PI_Q29  = 31'd1686629713;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    localparam logic [31:0]          RESET_SAMPLE_INTERVAL = 32'd4294967;
    localparam logic [31:0]          RESET_TIME_DELAY      = 32'd0;
    localparam logic [31:0]          RESET_PEAK_FREQUENCY  = 32'd1638400;
    localparam logic [AMP_WIDTH-1:0] RESET_AMPLITUDE       = 24'd65536;
    localparam logic [NS_WIDTH-1:0]  RESET_NUM_SAMPLES     = 17'd1000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_TIME_DELAY      = 3'd1,
        REG_PEAK_FREQUENCY  = 3'd2,
        REG_AMPLITUDE       = 3'd3,
        REG_NUM_SAMPLES     = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [31:0]          sample_interval;
        logic [31:0]          time_delay;
        logic [31:0]          peak_frequency;
        logic [AMP_WIDTH-1:0] amplitude;
        logic [NS_WIDTH-1:0]  num_samples;
    } cfg_t;

    typedef struct packed {
        logic zero;
        logic oor;
        logic last;
    } tag_t;

    typedef struct packed {
        tag_t               tag;
        logic [A_WIDTH-1:0] a;
        logic [N_WIDTH-1:0] n;
        logic [31:0]        r;
        logic [32:0]        p;
    } hitem_t;

    function automatic logic [A_WIDTH-1:0] ln2_mult(input logic [N_WIDTH-1:0] n);
        return A_WIDTH'(n) * A_WIDTH'(LN2_Q32);
    endfunction

    // floor(2^32/k), with all ones for k of one
    function automatic logic [31:0] recip(input logic [K_WIDTH-1:0] k);
        logic [31:0] m;
        case (k)
            4'd1:    m = 32'hFFFF_FFFF;
            4'd2:    m = 32'h8000_0000;
            4'd3:    m = 32'h5555_5555;
            4'd4:    m = 32'h4000_0000;
            4'd5:    m = 32'h3333_3333;
            4'd6:    m = 32'h2AAA_AAAA;
            4'd7:    m = 32'h2492_4924;
            4'd8:    m = 32'h2000_0000;
            4'd9:    m = 32'h1C71_C71C;
            4'd10:   m = 32'h1999_9999;
            4'd11:   m = 32'h1745_D174;
            4'd12:   m = 32'h1555_5555;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/rws_front.sv =====
// Front pipeline: time offset, scaled argument, square and split of a by ln2.
// Depends on rws_pkg.
module rws_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rws_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    input  logic [rws_pkg::INDEX_WIDTH-1:0] idx,
    output logic                           out_valid,
    output rws_pkg::hitem_t                out_item
);

    localparam int PW = rws_pkg::POS_WIDTH;
    localparam int IW = rws_pkg::INDEX_WIDTH;
    localparam int AW = rws_pkg::A_WIDTH;
    localparam int CW = rws_pkg::CMP_WIDTH;

    logic [7:0] valid_reg;

    rws_pkg::tag_t   t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   at_reg;
    logic [IW+31:0]  hi_reg;
    logic [63:0]     lo_reg;
    logic [32:0]     x_reg;
    logic [30:0]     y_reg;
    logic [AW-1:0]   a6_reg, a7_reg;
    logic [rws_pkg::N_WIDTH-1:0] n7_reg;
    rws_pkg::hitem_t item_reg;

    logic [CW-1:0]   idx_c, ns_c;
    rws_pkg::tag_t   t1_next, t4_next, t6_next, t7_next;
    logic [PW-1:0]   dly, at_next;
    logic [49:0]     prod;
    logic [63:0]     xp;
    logic [61:0]     sq;
    logic [rws_pkg::N_WIDTH-1:0] n_next;

    always_comb
    begin
        idx_c        = CW'(idx);
        ns_c         = CW'(cfg.num_samples);
        t1_next.oor  = idx_c >= ns_c;
        t1_next.last = (idx_c + CW'(1)) == ns_c;
        t1_next.zero = t1_next.oor;
    end

    always_comb
    begin
        dly     = PW'({cfg.time_delay, 8'd0});
        at_next = (pos_reg >= dly) ? pos_reg - dly : dly - pos_reg;
    end

    always_comb
    begin
        t4_next      = t3_reg;
        prod         = {hi_reg[16:0], 32'd0} + 50'(lo_reg[48:0]);
        t4_next.zero = t3_reg.zero || (hi_reg >= (IW+32)'(64'd1 << 17))
                       || (lo_reg >= (64'd1 << 49)) || prod[49];
    end

    always_comb
    begin
        xp = 64'(x_reg) * 64'(rws_pkg::PI_Q29);
        sq = 62'(y_reg) * 62'(y_reg);
        t6_next      = t5_reg;
        t6_next.zero = t5_reg.zero || (y_reg >= 31'(64'd5 << 28));
    end

    always_comb
    begin
        t7_next      = t6_reg;
        t7_next.zero = t6_reg.zero || (a6_reg > AW'(64'd24 << 32));
        n_next       = '0;
        for (int k = 1; k <= rws_pkg::N_MAX; k++)
        begin
            n_next = n_next + rws_pkg::N_WIDTH'(a6_reg >= rws_pkg::ln2_mult(rws_pkg::N_WIDTH'(k)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= t1_next;
        pos_reg <= PW'(idx) * PW'(cfg.sample_interval);
        t2_reg  <= t1_reg;
        at_reg  <= at_next;
        t3_reg  <= t2_reg;
        hi_reg  <= (IW+32)'(cfg.peak_frequency) * (IW+32)'(at_reg[PW-1:32]);
        lo_reg  <= 64'(cfg.peak_frequency) * 64'(at_reg[31:0]);
        t4_reg  <= t4_next;
        x_reg   <= prod[48:16];
        t5_reg  <= t4_reg;
        y_reg   <= xp[63:33];
        t6_reg  <= t6_next;
        a6_reg  <= sq[60:24];
        t7_reg  <= t7_next;
        a7_reg  <= a6_reg;
        n7_reg  <= n_next;
        item_reg.tag <= t7_reg;
        item_reg.a   <= a7_reg;
        item_reg.n   <= n7_reg;
        item_reg.r   <= 32'(a7_reg - rws_pkg::ln2_mult(n7_reg));
        item_reg.p   <= rws_pkg::ONE_Q32;
    end

    assign out_valid = valid_reg[7];
    assign out_item  = item_reg;

endmodule

// ===== hdl/rws_hstep.sv =====
// One Horner step of the exp(-r) series: p = 1 - ((r*p) >> 32) / k, in three stages.
// Depends on rws_pkg.
module rws_hstep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rws_pkg::K_WIDTH-1:0]   k,
    input  logic                          in_valid,
    input  rws_pkg::hitem_t               in_item,
    output logic                          out_valid,
    output rws_pkg::hitem_t               out_item
);

    logic [2:0]      valid_reg;
    rws_pkg::hitem_t a_item_reg, b_item_reg, c_item_reg;
    logic [31:0]     m_a_reg, m_b_reg, q0_reg;

    logic [64:0]     rp;
    logic [63:0]     mq;
    logic [35:0]     rem;
    logic [31:0]     q;
    rws_pkg::hitem_t c_item_next;

    always_comb
    begin
        rp  = 65'(in_item.r) * 65'(in_item.p);
        mq  = 64'(m_a_reg) * 64'(rws_pkg::recip(k));
        rem = 36'(m_b_reg) - 36'(q0_reg) * 36'(k);
        q   = q0_reg + 32'(rem >= 36'(k));
        c_item_next   = b_item_reg;
        c_item_next.p = rws_pkg::ONE_Q32 - 33'(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= in_item;
        m_a_reg    <= rp[63:32];
        b_item_reg <= a_item_reg;
        m_b_reg    <= m_a_reg;
        q0_reg     <= mq[63:32];
        c_item_reg <= c_item_next;
    end

    assign out_valid = valid_reg[2];
    assign out_item  = c_item_reg;

endmodule

// ===== hdl/rws_back.sv =====
// Back pipeline: exponent shift, (1-2a) weighting, amplitude scaling and saturation.
// Depends on rws_pkg.
module rws_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rws_pkg::AMP_WIDTH-1:0]   amplitude,
    input  logic                            in_valid,
    input  rws_pkg::hitem_t                 in_item,
    output logic                            done,
    output logic signed [31:0]              sample_value,
    output logic                            last_sample,
    output logic                            out_of_range
);

    localparam int AW = rws_pkg::A_WIDTH;

    logic [3:0]    valid_reg;
    rws_pkg::tag_t t1_reg, t2_reg, t3_reg;
    logic [24:0]   e8_reg;
    logic [AW:0]   wmag_reg;
    logic          wneg1_reg, wneg2_reg;
    logic [38:0]   gmag_reg;
    logic [31:0]   mag_reg;
    logic          neg_reg;
    logic [31:0]   value_reg;
    logic          last_reg, oor_reg;

    logic [32:0]   e;
    logic [AW:0]   two_a, one_w;
    logic          wneg_next;
    logic [62:0]   wg;
    logic [rws_pkg::AMP_WIDTH-1:0] amag;
    logic [63:0]   sm;
    logic [31:0]   value_next;

    always_comb
    begin
        e         = in_item.p >> in_item.n;
        two_a     = {in_item.a, 1'b0};
        one_w     = (AW+1)'(rws_pkg::ONE_Q32);
        wneg_next = two_a > one_w;
        wg        = 63'(wmag_reg) * 63'(e8_reg);
        amag      = amplitude[rws_pkg::AMP_WIDTH-1] ? rws_pkg::AMP_WIDTH'(-amplitude) : amplitude;
        sm        = 64'(gmag_reg) * 64'(amag) + (64'd1 << 31);
    end

    always_comb
    begin
        if (t3_reg.zero)
        begin
            value_next = '0;
        end
        else if (neg_reg)
        begin
            value_next = (mag_reg > 32'h8000_0000) ? 32'h8000_0000 : 32'(-mag_reg);
        end
        else
        begin
            value_next = (mag_reg > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg    <= in_item.tag;
        e8_reg    <= e[32:8];
        wmag_reg  <= wneg_next ? two_a - one_w : one_w - two_a;
        wneg1_reg <= wneg_next;
        t2_reg    <= t1_reg;
        gmag_reg  <= wg[62:24];
        wneg2_reg <= wneg1_reg;
        t3_reg    <= t2_reg;
        mag_reg   <= sm[63:32];
        neg_reg   <= wneg2_reg ^ amplitude[rws_pkg::AMP_WIDTH-1];
        value_reg <= value_next;
        last_reg  <= t3_reg.last && !t3_reg.oor;
        oor_reg   <= t3_reg.oor;
    end

    assign done         = valid_reg[3];
    assign sample_value = value_reg;
    assign last_sample  = last_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== hdl/ricker_wavelet_sample_unit.sv =====
// Top level of the Ricker wavelet sample unit: configuration registers and pipeline.
// Depends on rws_pkg, rws_front, rws_hstep and rws_back.
//
// Usage: raise start with sample_index for one cycle per sample; busy stays low,
// so a new index may be issued on every clock. One result follows each index.
// done marks the single cycle in which sample_value, last_sample and
// out_of_range are valid; the receiver must take it then, it cannot hold it off.
// Throughput is one sample per clock. The depth is set by the input register,
// the twelve Horner steps of the exp(-r) series, three stages each (multiply,
// reciprocal multiply, correction), and eight front and four back stages.
// Configuration: a write beat on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Indices 0..4 select sample_interval,
// time_delay, peak_frequency, amplitude and num_samples; others are dropped.
// Write only while no sample is in flight.
// Reset clears the pipeline valid bits and loads the default registers.
module ricker_wavelet_sample_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [15:0]                            sample_index,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rws_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [31:0]                            cfg_data,
    output logic                                   done,
    output logic signed [31:0]                     sample_value,
    output logic                                   last_sample,
    output logic                                   out_of_range
);

    localparam int HT = rws_pkg::HORNER_TERMS;

    rws_pkg::cfg_t cfg_reg;
    logic          s0_valid_reg;
    logic [rws_pkg::INDEX_WIDTH-1:0] s0_index_reg;

    logic            h_valid [0:HT];
    rws_pkg::hitem_t h_item  [0:HT];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval <= rws_pkg::RESET_SAMPLE_INTERVAL;
            cfg_reg.time_delay      <= rws_pkg::RESET_TIME_DELAY;
            cfg_reg.peak_frequency  <= rws_pkg::RESET_PEAK_FREQUENCY;
            cfg_reg.amplitude       <= rws_pkg::RESET_AMPLITUDE;
            cfg_reg.num_samples     <= rws_pkg::RESET_NUM_SAMPLES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rws_pkg::REG_SAMPLE_INTERVAL: cfg_reg.sample_interval <= cfg_data;
                rws_pkg::REG_TIME_DELAY:      cfg_reg.time_delay      <= cfg_data;
                rws_pkg::REG_PEAK_FREQUENCY:  cfg_reg.peak_frequency  <= cfg_data;
                rws_pkg::REG_AMPLITUDE:
                    cfg_reg.amplitude <= cfg_data[rws_pkg::AMP_WIDTH-1:0];
                rws_pkg::REG_NUM_SAMPLES:
                    cfg_reg.num_samples <= cfg_data[rws_pkg::NS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_index_reg <= sample_index[rws_pkg::INDEX_WIDTH-1:0];
    end

    rws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s0_valid_reg),
        .idx       (s0_index_reg),
        .out_valid (h_valid[0]),
        .out_item  (h_item[0])
    );

    for (genvar j = 0; j < HT; j++)
    begin : g_horner
        rws_hstep u_hstep (
            .clk       (clk),
            .rst_n     (rst_n),
            .k         (rws_pkg::K_WIDTH'(HT - j)),
            .in_valid  (h_valid[j]),
            .in_item   (h_item[j]),
            .out_valid (h_valid[j+1]),
            .out_item  (h_item[j+1])
        );
    end

    rws_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .amplitude    (cfg_reg.amplitude),
        .in_valid     (h_valid[HT]),
        .in_item      (h_item[HT]),
        .done         (done),
        .sample_value (sample_value),
        .last_sample  (last_sample),
        .out_of_range (out_of_range)
    );

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_range |-> sample_value == 32'sd0)
        else $error("out-of-range beat carries a non-zero sample");

    a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(last_sample && out_of_range))
        else $error("last and out-of-range flagged on one beat");

    a_exp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid[HT] |-> (h_item[HT].p != 33'd0) && (h_item[HT].p <= rws_pkg::ONE_Q32))
        else $error("series result outside (0, 1]");

endmodule

// ===== sim/rws_checker.sv =====
`timescale 1ns / 100ps
// Checker for the Ricker wavelet sample unit: watches the config and sample channels,
// predicts each sample and compares it with the block's output. Depends on rws_pkg.
module rws_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [15:0]                         sample_index,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                done,
    input  logic signed [31:0]                  sample_value,
    input  logic                                last_sample,
    input  logic                                out_of_range,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  samples_seen
);

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        oor;
    } sample_t;

    localparam logic [63:0] ONE = 64'h1_0000_0000;
    localparam logic [63:0] LN2 = 64'd2977044472;

    logic [31:0] dt_q, t0_q, f0_q;
    logic signed [23:0] amp_q;
    logic [16:0] len_q;
    sample_t expected_samples[$];

    function automatic logic [63:0] neg_exp(input logic [63:0] a);
        logic [63:0] n, r, p;
        n = a / LN2;
        r = a - n * LN2;
        p = ONE;
        for (int k = rws_pkg::HORNER_TERMS; k >= 1; k--)
            p = ONE - ((r * p) >> 32) / k;
        if (n > 63)
            return 64'd0;
        return p >> n;
    endfunction

    function automatic logic [31:0] wavelet_value(input logic [63:0] idx);
        logic [63:0] pos, dly, at, th, tl, hi, lo, prod, x, y, a, e, two_a, wmag, gmag;
        logic [63:0] amag, mag;
        logic wneg, neg;
        pos = idx * dt_q;
        dly = {32'd0, t0_q} << 8;
        at = pos >= dly ? pos - dly : dly - pos;
        th = at >> 32;
        tl = at & 64'hFFFF_FFFF;
        hi = f0_q * th;
        lo = f0_q * tl;
        if (hi >= (64'd1 << 17) || lo >= (64'd1 << 49))
            return 32'd0;
        prod = (hi << 32) + lo;
        if (prod >= (64'd1 << 49))
            return 32'd0;
        x = prod >> 16;
        y = ((x * 64'd1686629713) >> 29) >> 4;
        if (y >= (64'd5 << 28))
            return 32'd0;
        a = (y * y) >> 24;
        if (a > (64'd24 << 32))
            return 32'd0;
        e = neg_exp(a);
        two_a = a << 1;
        wneg = two_a > ONE;
        wmag = wneg ? two_a - ONE : ONE - two_a;
        gmag = (wmag * (e >> 8)) >> 24;
        neg = wneg != (amp_q < 0);
        amag = (amp_q < 0) ? -64'(amp_q) : 64'(amp_q);
        mag = (gmag * amag + (64'd1 << 31)) >> 32;
        if (neg)
        begin
            if (mag > (64'd1 << 31))
                mag = 64'd1 << 31;
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic sample_t predict_sample(input logic [15:0] idx);
        sample_t s;
        if ({1'b0, idx} >= len_q)
        begin
            s.value = 32'd0;
            s.last = 1'b0;
            s.oor = 1'b1;
        end
        else
        begin
            s.value = wavelet_value({48'd0, idx});
            s.last = ({1'b0, idx} + 17'd1) == len_q;
            s.oor = 1'b0;
        end
        return s;
    endfunction

    assign pending = expected_samples.size();

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            dt_q <= rws_pkg::RESET_SAMPLE_INTERVAL;
            t0_q <= rws_pkg::RESET_TIME_DELAY;
            f0_q <= rws_pkg::RESET_PEAK_FREQUENCY;
            amp_q <= rws_pkg::RESET_AMPLITUDE;
            len_q <= rws_pkg::RESET_NUM_SAMPLES;
            fail_count <= 0;
            samples_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                samples_seen <= samples_seen + 1;
                if (expected_samples.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected sample %h", $realtime, sample_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (want.value !== sample_value || want.last !== last_sample
                        || want.oor !== out_of_range)
                    begin
                        if (fail_count < 10)
                            $display("%0t: sample exp %h/%b/%b got %h/%b/%b", $realtime,
                                     want.value, want.last, want.oor,
                                     sample_value, last_sample, out_of_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_samples.push_back(predict_sample(sample_index));
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    rws_pkg::REG_SAMPLE_INTERVAL: dt_q <= cfg_data;
                    rws_pkg::REG_TIME_DELAY:      t0_q <= cfg_data;
                    rws_pkg::REG_PEAK_FREQUENCY:  f0_q <= cfg_data;
                    rws_pkg::REG_AMPLITUDE:       amp_q <= cfg_data[23:0];
                    rws_pkg::REG_NUM_SAMPLES:     len_q <= cfg_data[16:0];
                    default: ;
                endcase
        end
    end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the Ricker wavelet sample unit testbench: clock, reset, stimulus and verdict.
// Depends on rws_pkg, ricker_wavelet_sample_unit and rws_checker.
module testbench;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [15:0] sample_index = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic done;
    logic signed [31:0] sample_value;
    logic last_sample;
    logic out_of_range;
    int fail_count;
    int pending;
    int samples_seen;
    int cfg_writes = 0;
    logic [16:0] cur_len = rws_pkg::RESET_NUM_SAMPLES;

    always #5 clk = ~clk;

    ricker_wavelet_sample_unit uut (.*);

    rws_checker checker_i (.*);

    task automatic write_reg(input logic [rws_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [31:0] val);
        @(negedge clk);
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == rws_pkg::CFG_INDEX_WIDTH'(rws_pkg::REG_NUM_SAMPLES))
            cur_len = val[16:0];
    endtask

    task automatic send_index(input logic [15:0] idx);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        sample_index <= idx;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_index;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && cur_len > 1)
            return 16'($urandom_range(0, cur_len - 1));
        if (sel == 6 && cur_len > 0)
            return 16'(cur_len - 1);
        if (sel == 7)
            return 16'(cur_len);
        return 16'($urandom);
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_index(16'd0);
        send_index(16'd1);
        send_index(16'd500);
        send_index(16'd998);
        send_index(16'd999);
        send_index(16'd1000);
        send_index(16'hFFFF);
        send_index(16'h5555);
        send_index(16'hAAAA);
        drain();

        write_reg(rws_pkg::REG_SAMPLE_INTERVAL, 32'hFFFF_FFFF);
        write_reg(rws_pkg::REG_TIME_DELAY, 32'hFFFF_FFFF);
        write_reg(rws_pkg::REG_PEAK_FREQUENCY, 32'd0);
        write_reg(rws_pkg::REG_AMPLITUDE, 32'h0080_0000);
        write_reg(rws_pkg::REG_NUM_SAMPLES, 32'd65536);
        write_reg(3'd7, 32'hDEAD_BEEF);
        send_index(16'd0);
        send_index(16'hFFFF);
        send_index(16'd255);
        drain();
        write_reg(rws_pkg::REG_PEAK_FREQUENCY, 32'hFFFF_FFFF);
        write_reg(rws_pkg::REG_AMPLITUDE, 32'h007F_FFFF);
        send_index(16'd0);
        send_index(16'hFFFF);
        send_index(16'd256);
        drain();
        write_reg(rws_pkg::REG_NUM_SAMPLES, 32'd0);
        send_index(16'd0);
        send_index(16'd7);
        drain();
        write_reg(rws_pkg::REG_NUM_SAMPLES, 32'd1);
        send_index(16'd0);
        send_index(16'd1);
        drain();

        for (int ph = 0; ph < 11; ph++)
        begin
            logic [31:0] dt, f0, t0;
            f0 = $urandom_range(65536 * 5, 65536 * 80);
            dt = $urandom_range(2000000, 40000000);
            t0 = 32'($urandom_range(0, 16777216 / 8));
            if (ph == 0)
                dt = $urandom;
            if (ph == 1)
                f0 = $urandom;
            write_reg(rws_pkg::REG_SAMPLE_INTERVAL, dt);
            write_reg(rws_pkg::REG_TIME_DELAY, ph == 2 ? $urandom : t0);
            write_reg(rws_pkg::REG_PEAK_FREQUENCY, f0);
            write_reg(rws_pkg::REG_AMPLITUDE, ph == 3 ? 32'h0080_0000 : $urandom);
            write_reg(rws_pkg::REG_NUM_SAMPLES,
                      ph == 4 ? 32'd65536 : $urandom_range(1, 400));
            for (int k = 0; k < 50; k++)
                send_index(rand_index());
            drain();
        end

        $display("run: %0d samples checked over %0d register writes",
                 samples_seen, cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/rws_pkg.sv
hdl/rws_front.sv
hdl/rws_hstep.sv
hdl/rws_back.sv
hdl/ricker_wavelet_sample_unit.sv
sim/rws_checker.sv
sim/testbench.sv
